[hw/rtl/flsa_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_pkg: shared types and constants for the free-list allocator
// Field widths, opcodes, status codes and the request/response beats.
// ----------------------------------------------------------------------------
package flsa_pkg;

  localparam int ARENA_UNITS_DEF = 4096;
  localparam int UNIT_BYTES_DEF  = 16;

  localparam int BYTES_W = 16;
  localparam int ADDR_W  = 12;
  localparam int GROW_W  = 13;

  localparam logic [GROW_W-1:0] GROW_MIN_RESET = 13'd1024;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic ST_DONE    = 1'b0;
  localparam logic ST_NOSPACE = 1'b1;

  typedef struct packed {
    logic               opcode;
    logic [BYTES_W-1:0] request_bytes;
    logic [ADDR_W-1:0]  block_address;
  } flsa_req_t;

  typedef struct packed {
    logic              status;
    logic [ADDR_W-1:0] address;
  } flsa_rsp_t;

endpackage

[hw/rtl/flsa_if.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_if: channel interfaces of the allocator
// Request, response and configuration channels with valid/ready.
// ----------------------------------------------------------------------------
interface flsa_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [15:0] request_bytes;
  logic [11:0] block_address;

  modport source (output valid, output opcode, output request_bytes,
                  output block_address, input ready);
  modport sink (input valid, input opcode, input request_bytes,
                input block_address, output ready);
endinterface

interface flsa_rsp_if;
  logic        valid;
  logic        ready;
  logic        status;
  logic [11:0] address;

  modport source (output valid, output status, output address, input ready);
  modport sink (input valid, input status, input address, output ready);
endinterface

interface flsa_cfg_if;
  logic        valid;
  logic        ready;
  logic [12:0] grow_min_units;

  modport source (output valid, output grow_min_units, input ready);
  modport sink (input valid, input grow_min_units, output ready);
endinterface

[hw/rtl/flsa_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data (read-old).
// ----------------------------------------------------------------------------
module flsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[hw/rtl/flsa_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// flsa_ctrl: list-walk sequencer of the allocator
// Walks the free list one header per cycle over the link and size RAMs,
// splits, unlinks, grows the arena and coalesces freed blocks.
// ----------------------------------------------------------------------------
module flsa_ctrl #(
  parameter int ArenaUnits = flsa_pkg::ARENA_UNITS_DEF,
  parameter int UnitBytes  = flsa_pkg::UNIT_BYTES_DEF
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  flsa_pkg::flsa_req_t         req_i,
  input  logic [flsa_pkg::GROW_W-1:0] grow_min_i,
  output logic                        idle_o,
  output logic                        done_o,
  output flsa_pkg::flsa_rsp_t         rsp_o
);
  import flsa_pkg::*;

  localparam int AW        = $clog2(ArenaUnits);
  localparam int SW        = AW + 1;
  localparam int UW        = AW + 1;
  localparam int NW        = BYTES_W + 1;
  localparam int WalkLimit = 2 * ArenaUnits + 8;
  localparam int CW        = $clog2(WalkLimit + 2);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_AINIT  = 4'd1;
  localparam logic [3:0] S_AGETP  = 4'd2;
  localparam logic [3:0] S_ACHECK = 4'd3;
  localparam logic [3:0] S_ASPLIT = 4'd4;
  localparam logic [3:0] S_APOST  = 4'd5;
  localparam logic [3:0] S_FCHK   = 4'd6;
  localparam logic [3:0] S_RSTART = 4'd7;
  localparam logic [3:0] S_RWALK  = 4'd8;
  localparam logic [3:0] S_RRD1   = 4'd9;
  localparam logic [3:0] S_RRD2   = 4'd10;
  localparam logic [3:0] S_RRD3   = 4'd11;
  localparam logic [3:0] S_RWR2   = 4'd12;
  localparam logic [3:0] S_DONE   = 4'd13;

  logic [3:0]    state_q, state_d;
  logic [NW-1:0] nunits_q, nunits_d;
  logic [AW-1:0] prev_q, prev_d, p_q, p_d, hb_q, hb_d, up_q, up_d;
  logic [AW-1:0] base_q, base_d, lu_q, lu_d, lh_q, lh_d, rover_q, rover_d;
  logic [SW-1:0] sh_q, sh_d, su_q, su_d, sp_q, sp_d, shn_q, shn_d;
  logic [CW-1:0] an_q, an_d, rn_q, rn_d;
  logic [UW-1:0] untouched_q, untouched_d;
  logic          started_q, started_d, ret_alloc_q, ret_alloc_d;
  flsa_rsp_t     res_q, res_d;

  logic          lk_we, sz_we;
  logic [AW-1:0] lk_waddr, lk_wdata, lk_raddr, lk_rdata;
  logic [AW-1:0] sz_waddr, sz_raddr;
  logic [SW-1:0] sz_wdata, sz_rdata;

  flsa_ram #(.Width(AW), .Depth(ArenaUnits)) u_link_ram (
    .clk_i  (clk_i),
    .we_i   (lk_we),
    .waddr_i(lk_waddr),
    .wdata_i(lk_wdata),
    .raddr_i(lk_raddr),
    .rdata_o(lk_rdata)
  );

  flsa_ram #(.Width(SW), .Depth(ArenaUnits)) u_size_ram (
    .clk_i  (clk_i),
    .we_i   (sz_we),
    .waddr_i(sz_waddr),
    .wdata_i(sz_wdata),
    .raddr_i(sz_raddr),
    .rdata_o(sz_rdata)
  );

  // sequencer
  always_comb begin
    logic [31:0] nu;
    logic [31:0] tmp;
    logic [SW-1:0] newsz;
    logic brk, mrg;
    state_d     = state_q;
    nunits_d    = nunits_q;
    prev_d      = prev_q;
    p_d         = p_q;
    hb_d        = hb_q;
    up_d        = up_q;
    base_d      = base_q;
    lu_d        = lu_q;
    lh_d        = lh_q;
    rover_d     = rover_q;
    sh_d        = sh_q;
    su_d        = su_q;
    sp_d        = sp_q;
    shn_d       = shn_q;
    an_d        = an_q;
    rn_d        = rn_q;
    untouched_d = untouched_q;
    started_d   = started_q;
    ret_alloc_d = ret_alloc_q;
    res_d       = res_q;
    lk_we       = 1'b0;
    lk_waddr    = '0;
    lk_wdata    = '0;
    lk_raddr    = '0;
    sz_we       = 1'b0;
    sz_waddr    = '0;
    sz_wdata    = '0;
    sz_raddr    = '0;
    nu          = '0;
    tmp         = '0;
    newsz       = '0;
    brk         = 1'b0;
    mrg         = 1'b0;

    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          res_d.status  = ST_DONE;
          res_d.address = '0;
          if (req_i.opcode == OP_ALLOC) begin
            nunits_d = NW'((32'(req_i.request_bytes) + UnitBytes - 1) / UnitBytes + 1);
            an_d     = '0;
            if (!started_q) begin
              // set up the sentinel
              lk_we     = 1'b1;
              lk_waddr  = '0;
              lk_wdata  = '0;
              sz_we     = 1'b1;
              sz_waddr  = '0;
              sz_wdata  = '0;
              rover_d   = '0;
              started_d = 1'b1;
              prev_d    = '0;
            end else begin
              prev_d = rover_q;
            end
            state_d = S_AINIT;
          end else if (started_q && req_i.block_address != '0 &&
                       32'(req_i.block_address) < 32'(untouched_q)) begin
            hb_d        = AW'(req_i.block_address - 1'b1);
            sz_raddr    = AW'(req_i.block_address - 1'b1);
            ret_alloc_d = 1'b0;
            state_d     = S_FCHK;
          end else begin
            state_d = S_DONE;
          end
        end
      end

      S_AINIT: begin
        lk_raddr = prev_q;
        state_d  = S_AGETP;
      end

      S_AGETP: begin
        p_d      = lk_rdata;
        sz_raddr = lk_rdata;
        lk_raddr = lk_rdata;
        state_d  = S_ACHECK;
      end

      S_ACHECK: begin
        if (32'(sz_rdata) >= 32'(nunits_q)) begin
          rover_d = prev_q;
          if (32'(sz_rdata) == 32'(nunits_q)) begin
            // exact fit: unlink
            lk_we         = 1'b1;
            lk_waddr      = prev_q;
            lk_wdata      = lk_rdata;
            res_d.address = ADDR_W'(32'(p_q) + 1);
            state_d       = S_DONE;
          end else begin
            // hand out the tail
            newsz    = sz_rdata - SW'(nunits_q);
            sz_we    = 1'b1;
            sz_waddr = p_q;
            sz_wdata = newsz;
            base_d   = AW'(32'(p_q) + 32'(newsz));
            state_d  = S_ASPLIT;
          end
        end else if (p_q == rover_q) begin
          // list wrapped: grow from the untouched region
          nu = (32'(nunits_q) < 32'(grow_min_i)) ? 32'(grow_min_i) : 32'(nunits_q);
          if (32'(untouched_q) + nu > 32'(ArenaUnits)) begin
            res_d.status = ST_NOSPACE;
            state_d      = S_DONE;
          end else begin
            sz_we       = 1'b1;
            sz_waddr    = AW'(untouched_q);
            sz_wdata    = SW'(nu);
            hb_d        = AW'(untouched_q);
            untouched_d = UW'(32'(untouched_q) + nu);
            ret_alloc_d = 1'b1;
            rn_d        = '0;
            state_d     = S_RSTART;
          end
        end else if (32'(an_q) + 1 > 32'(WalkLimit)) begin
          res_d.status = ST_NOSPACE;
          state_d      = S_DONE;
        end else begin
          // advance one header
          an_d     = an_q + 1'b1;
          prev_d   = p_q;
          p_d      = lk_rdata;
          sz_raddr = lk_rdata;
          lk_raddr = lk_rdata;
        end
      end

      S_ASPLIT: begin
        sz_we         = 1'b1;
        sz_waddr      = base_q;
        sz_wdata      = SW'(nunits_q);
        res_d.address = ADDR_W'(32'(base_q) + 1);
        state_d       = S_DONE;
      end

      S_APOST: begin
        if (32'(an_q) + 1 > 32'(WalkLimit)) begin
          res_d.status = ST_NOSPACE;
          state_d      = S_DONE;
        end else begin
          an_d     = an_q + 1'b1;
          prev_d   = rover_q;
          lk_raddr = rover_q;
          state_d  = S_AGETP;
        end
      end

      S_FCHK: begin
        rn_d    = '0;
        state_d = (sz_rdata != '0) ? S_RSTART : S_DONE;
      end

      S_RSTART: begin
        p_d      = rover_q;
        lk_raddr = rover_q;
        state_d  = S_RWALK;
      end

      S_RWALK: begin
        brk = (hb_q > p_q && hb_q < lk_rdata) ||
              (p_q >= lk_rdata && (hb_q > p_q || hb_q < lk_rdata));
        if (brk) begin
          up_d     = lk_rdata;
          sz_raddr = hb_q;
          lk_raddr = lk_rdata;
          state_d  = S_RRD1;
        end else if (32'(rn_q) + 1 > 32'(WalkLimit)) begin
          // drop the insert
          state_d = ret_alloc_q ? S_APOST : S_DONE;
        end else begin
          rn_d     = rn_q + 1'b1;
          p_d      = lk_rdata;
          lk_raddr = lk_rdata;
        end
      end

      S_RRD1: begin
        sh_d     = sz_rdata;
        lu_d     = lk_rdata;
        sz_raddr = up_q;
        state_d  = S_RRD2;
      end

      S_RRD2: begin
        su_d     = sz_rdata;
        sz_raddr = p_q;
        state_d  = S_RRD3;
      end

      S_RRD3: begin
        // join with the block above
        sp_d = sz_rdata;
        mrg  = (32'(hb_q) + 32'(sh_q)) == 32'(up_q);
        tmp  = 32'(sh_q) + 32'(su_q);
        shn_d    = mrg ? SW'(tmp) : sh_q;
        lh_d     = mrg ? lu_q : up_q;
        sz_we    = 1'b1;
        sz_waddr = hb_q;
        sz_wdata = mrg ? SW'(tmp) : sh_q;
        lk_we    = 1'b1;
        lk_waddr = hb_q;
        lk_wdata = mrg ? lu_q : up_q;
        state_d  = S_RWR2;
      end

      S_RWR2: begin
        // join with the block below
        mrg      = (32'(p_q) + 32'(sp_q)) == 32'(hb_q);
        tmp      = 32'(sp_q) + 32'(shn_q);
        lk_we    = 1'b1;
        lk_waddr = p_q;
        lk_wdata = mrg ? lh_q : hb_q;
        sz_we    = mrg;
        sz_waddr = p_q;
        sz_wdata = SW'(tmp);
        rover_d  = p_q;
        state_d  = ret_alloc_q ? S_APOST : S_DONE;
      end

      S_DONE: begin
        state_d = S_IDLE;
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rover_q     <= '0;
      untouched_q <= UW'(1);
      started_q   <= 1'b0;
      an_q        <= '0;
      rn_q        <= '0;
      ret_alloc_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rover_q     <= rover_d;
      untouched_q <= untouched_d;
      started_q   <= started_d;
      an_q        <= an_d;
      rn_q        <= rn_d;
      ret_alloc_q <= ret_alloc_d;
    end
  end

  // working registers
  always_ff @(posedge clk_i) begin
    nunits_q <= nunits_d;
    prev_q   <= prev_d;
    p_q      <= p_d;
    hb_q     <= hb_d;
    up_q     <= up_d;
    base_q   <= base_d;
    lu_q     <= lu_d;
    lh_q     <= lh_d;
    sh_q     <= sh_d;
    su_q     <= su_d;
    sp_q     <= sp_d;
    shn_q    <= shn_d;
    res_q    <= res_d;
  end

  assign idle_o = (state_q == S_IDLE);
  assign done_o = (state_q == S_DONE);
  assign rsp_o  = res_q;

endmodule

[hw/rtl/free_list_storage_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// free_list_storage_allocator: next-fit free-list allocator, top level
// Holds the grow minimum register and the response register around the
// list-walk sequencer.
// ----------------------------------------------------------------------------
//  channel  dir  payload                                  beat when
//  req_i    in   opcode, request_bytes, block_address     valid && ready
//  rsp_o    out  status, address                          valid && ready
//  cfg_i    in   grow_min_units                           valid && ready
//
//  An allocate walks the free-list headers from the rover on; a grow
//  adds an insert walk over the headers before the allocate resumes.
//  A free walks the headers to its spot, then merges and links it.
//  One request is in flight at a time; req_i.ready drops until the
//  response register is empty and the sequencer is idle.
//  Reset empties the list; the link and size RAMs need no clearing.
// ----------------------------------------------------------------------------
module free_list_storage_allocator #(
  parameter int ArenaUnits = flsa_pkg::ARENA_UNITS_DEF,
  parameter int UnitBytes  = flsa_pkg::UNIT_BYTES_DEF
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  flsa_req_if.sink   req_i,
  flsa_rsp_if.source rsp_o,
  flsa_cfg_if.sink   cfg_i
);
  import flsa_pkg::*;

  logic [GROW_W-1:0] grow_min_q;
  logic              out_valid_q;
  flsa_rsp_t         out_q;
  logic              idle, done;
  flsa_req_t         req;
  flsa_rsp_t         res;

  assign req.opcode        = req_i.opcode;
  assign req.request_bytes = req_i.request_bytes;
  assign req.block_address = req_i.block_address;

  assign req_i.ready = idle && !out_valid_q;
  assign cfg_i.ready = 1'b1;

  flsa_ctrl #(.ArenaUnits(ArenaUnits), .UnitBytes(UnitBytes)) u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (req_i.valid && req_i.ready),
    .req_i     (req),
    .grow_min_i(grow_min_q),
    .idle_o    (idle),
    .done_o    (done),
    .rsp_o     (res)
  );

  // hold the grow minimum
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grow_min_q <= GROW_MIN_RESET;
    end else if (cfg_i.valid) begin
      grow_min_q <= cfg_i.grow_min_units;
    end
  end

  // response register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done) begin
      out_valid_q <= 1'b1;
    end else if (rsp_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done) begin
      out_q <= res;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.status  = out_q.status;
  assign rsp_o.address = out_q.address;

endmodule

[dv/tb_free_list_storage_allocator.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_free_list_storage_allocator: self-checking bench for the allocator
// Drives allocate and free requests (a directed table, then random traffic
// over several grow minimum settings) and checks every response beat against
// the directed table's expected response or an in-bench model of the next-fit free list.
// ----------------------------------------------------------------------------
module tb_free_list_storage_allocator;
  import flsa_pkg::*;

  localparam int unsigned ARENA      = ARENA_UNITS_DEF;
  localparam int unsigned UNIT_SZ    = UNIT_BYTES_DEF;
  localparam int unsigned WALK_BOUND = 2 * ARENA + 8;
  localparam int unsigned CYCLE_CAP  = 4000000;
  localparam int          PHASE_LEN  = 190;

  logic clk_i;
  logic rst_ni;

  flsa_req_if req_if ();
  flsa_rsp_if rsp_if ();
  flsa_cfg_if cfg_if ();

  free_list_storage_allocator dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_if),
    .rsp_o  (rsp_if),
    .cfg_i  (cfg_if)
  );

  // Clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Free-list model state
  bit [ADDR_W-1:0] link_mem [ARENA];
  bit [GROW_W-1:0] size_mem [ARENA];
  int unsigned     rover_q;
  int unsigned     fresh_start;
  bit              list_up;
  int unsigned     grow_min;

  flsa_rsp_t   expected_rsp [$];
  int unsigned live_blocks  [$];
  int          error_count;
  bit          idle_on;
  int unsigned cycle_count;

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    $display("mismatch: %s got %0d want %0d", what, got, want);
    error_count++;
  endtask

  // Link header hb into the address-ordered list and coalesce neighbors
  function automatic bit insert_free(input int unsigned hb);
    int unsigned p, q, up, n;
    p = rover_q;
    n = 0;
    forever begin
      q = 32'(link_mem[p]);
      if (hb > p && hb < q) break;
      if (p >= q && (hb > p || hb < q)) break;
      p = q;
      n++;
      if (n > WALK_BOUND) return 1'b0;
    end
    up = 32'(link_mem[p]);
    if (hb + size_mem[hb] == up) begin
      size_mem[hb] = GROW_W'(size_mem[hb] + size_mem[up]);
      link_mem[hb] = link_mem[up];
    end else begin
      link_mem[hb] = ADDR_W'(up);
    end
    if (p + size_mem[p] == hb) begin
      size_mem[p] = GROW_W'(size_mem[p] + size_mem[hb]);
      link_mem[p] = link_mem[hb];
    end else begin
      link_mem[p] = ADDR_W'(hb);
    end
    rover_q = p;
    return 1'b1;
  endfunction

  // Carve a new block from the untouched region
  function automatic bit grow_arena(input int unsigned need);
    int unsigned nu, hb;
    nu = (need < grow_min) ? grow_min : need;
    hb = fresh_start;
    if (hb + nu > ARENA) return 1'b0;
    size_mem[hb % ARENA] = GROW_W'(nu);
    fresh_start = hb + nu;
    void'(insert_free(hb % ARENA));
    return 1'b1;
  endfunction

  // Work out the response of one request and advance the model
  function automatic flsa_rsp_t predict_response(input logic op,
                                                 input logic [BYTES_W-1:0] nbytes,
                                                 input logic [ADDR_W-1:0] addr);
    flsa_rsp_t   r;
    int unsigned nunits, prev, p, n;
    r.status  = ST_DONE;
    r.address = '0;
    if (op == OP_ALLOC) begin
      nunits = (32'(nbytes) + UNIT_SZ - 1) / UNIT_SZ + 1;
      if (!list_up) begin
        link_mem[0] = '0;
        size_mem[0] = '0;
        rover_q     = 0;
        list_up     = 1'b1;
      end
      prev = rover_q;
      p    = 32'(link_mem[prev]);
      n    = 0;
      forever begin
        if (size_mem[p] >= nunits) begin
          if (size_mem[p] == nunits) begin
            link_mem[prev] = link_mem[p];
          end else begin
            size_mem[p] = GROW_W'(size_mem[p] - nunits);
            p = (p + 32'(size_mem[p])) % ARENA;
            size_mem[p] = GROW_W'(nunits);
          end
          rover_q   = prev;
          r.address = ADDR_W'(p + 1);
          live_blocks.push_back(p + 1);
          return r;
        end
        if (p == rover_q) begin
          if (!grow_arena(nunits)) begin
            r.status = ST_NOSPACE;
            return r;
          end
          p = rover_q;
        end
        n++;
        if (n > WALK_BOUND) begin
          r.status = ST_NOSPACE;
          return r;
        end
        prev = p;
        p    = 32'(link_mem[p]);
      end
    end else begin
      if (list_up && addr != 0 && addr < fresh_start) begin
        if (size_mem[addr - 1] != 0) void'(insert_free(32'(addr) - 1));
      end
    end
    return r;
  endfunction

  // Response side: check beats, stall ready in random bursts
  int stall_left;
  always @(posedge clk_i or negedge rst_ni) begin
    flsa_rsp_t want;
    if (!rst_ni) begin
      rsp_if.ready <= 1'b0;
      stall_left   <= 0;
    end else begin
      if (rsp_if.valid && rsp_if.ready) begin
        if (expected_rsp.size() == 0) begin
          report_mismatch("unexpected response, address", 32'(rsp_if.address), 0);
        end else begin
          want = expected_rsp.pop_front();
          if (rsp_if.status !== want.status)
            report_mismatch("status", 32'(rsp_if.status), 32'(want.status));
          if (rsp_if.address !== want.address)
            report_mismatch("address", 32'(rsp_if.address), 32'(want.address));
        end
      end
      if (stall_left > 0) begin
        stall_left   <= stall_left - 1;
        rsp_if.ready <= 1'b0;
      end else if (idle_on && $urandom_range(0, 4) == 0) begin
        stall_left   <= $urandom_range(0, 5);
        rsp_if.ready <= 1'b0;
      end else begin
        rsp_if.ready <= 1'b1;
      end
    end
  end

  // Hard stop on a hang
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_CAP) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Send one request beat; hold valid until accepted, then predict
  task automatic send_request(input logic op, input logic [BYTES_W-1:0] nbytes,
                              input logic [ADDR_W-1:0] addr, input bit typed,
                              input flsa_rsp_t typed_rsp);
    flsa_rsp_t r;
    if (idle_on && $urandom_range(0, 3) == 0) begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
    req_if.valid         <= 1'b1;
    req_if.opcode        <= op;
    req_if.request_bytes <= nbytes;
    req_if.block_address <= addr;
    @(posedge clk_i);
    while (!req_if.ready) @(posedge clk_i);
    r = predict_response(op, nbytes, addr);
    expected_rsp.push_back(typed ? typed_rsp : r);
  endtask

  // Write the grow minimum while the block is idle
  task automatic write_grow_min(input logic [GROW_W-1:0] v);
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    cfg_if.valid          <= 1'b1;
    cfg_if.grow_min_units <= v;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    grow_min = 32'(v);
  endtask

  // One random request: mostly small allocates and frees of live blocks
  task automatic random_request();
    int unsigned pick, idx, a;
    flsa_rsp_t   none;
    none = '0;
    pick = $urandom_range(0, 99);
    if (live_blocks.size() > 40 && pick < 60) pick = 70;
    if (pick < 50) begin
      send_request(OP_ALLOC, BYTES_W'($urandom_range(0, 200)), ADDR_W'($urandom),
                   1'b0, none);
    end else if (pick < 56) begin
      send_request(OP_ALLOC, BYTES_W'($urandom_range(0, 65535)), ADDR_W'($urandom),
                   1'b0, none);
    end else if (pick < 92 && live_blocks.size() > 0) begin
      idx = $urandom_range(0, live_blocks.size() - 1);
      a   = live_blocks[idx];
      live_blocks.delete(idx);
      send_request(OP_FREE, BYTES_W'($urandom), ADDR_W'(a), 1'b0, none);
    end else begin
      // bad free: zero, sentinel user area, or beyond the grown arena
      case ($urandom_range(0, 2))
        0: a = 0;
        1: a = 1;
        default: a = (fresh_start <= ARENA - 1) ?
                     $urandom_range(fresh_start, ARENA - 1) : 0;
      endcase
      send_request(OP_FREE, BYTES_W'($urandom), ADDR_W'(a), 1'b0, none);
    end
  endtask

  typedef struct {
    logic              op;
    logic [15:0]       nbytes;
    logic [11:0]       addr;
    bit                typed;
    flsa_rsp_t         rsp;
  } stim_row_t;

  stim_row_t directed_rows [] = '{
    '{OP_FREE,  16'd0,     12'd5,    1'b1, '{ST_DONE,    12'd0}},    // free before list
    '{OP_ALLOC, 16'd0,     12'd0,    1'b1, '{ST_DONE,    12'd1025}}, // first grow
    '{OP_ALLOC, 16'd16,    12'd0,    1'b1, '{ST_DONE,    12'd1023}},
    '{OP_ALLOC, 16'd17,    12'd0,    1'b1, '{ST_DONE,    12'd1020}},
    '{OP_ALLOC, 16'hFFFF,  12'd0,    1'b1, '{ST_NOSPACE, 12'd0}},    // too big
    '{OP_FREE,  16'hFFFF,  12'd0,    1'b1, '{ST_DONE,    12'd0}},    // address zero
    '{OP_FREE,  16'd0,     12'd1,    1'b1, '{ST_DONE,    12'd0}},    // sentinel header
    '{OP_FREE,  16'd0,     12'hFFF,  1'b1, '{ST_DONE,    12'd0}},    // beyond arena
    '{OP_FREE,  16'd0,     12'd1023, 1'b0, '{ST_DONE,    12'd0}},
    '{OP_ALLOC, 16'd32,    12'd0,    1'b0, '{ST_DONE,    12'd0}},
    '{OP_FREE,  16'd0,     12'd1025, 1'b0, '{ST_DONE,    12'd0}},
    '{OP_FREE,  16'd0,     12'd1020, 1'b0, '{ST_DONE,    12'd0}},
    '{OP_ALLOC, 16'd16320, 12'd0,    1'b0, '{ST_DONE,    12'd0}},    // exact tail
    '{OP_ALLOC, 16'd48000, 12'd0,    1'b0, '{ST_DONE,    12'd0}},
    '{OP_ALLOC, 16'd1,     12'd0,    1'b0, '{ST_DONE,    12'd0}}
  };

  logic [GROW_W-1:0] grow_plan [] = '{13'd1, 13'd4096, 13'd37, 13'd1024, 13'd256};

  // Main sequence
  initial begin
    error_count = 0;
    cycle_count = 0;
    idle_on     = 1'b1;
    rover_q     = 0;
    fresh_start = 1;
    list_up     = 1'b0;
    grow_min    = 32'(GROW_MIN_RESET);
    req_if.valid          = 1'b0;
    req_if.opcode         = OP_ALLOC;
    req_if.request_bytes  = '0;
    req_if.block_address  = '0;
    cfg_if.valid          = 1'b0;
    cfg_if.grow_min_units = GROW_MIN_RESET;
    rsp_if.ready          = 1'b0;
    rst_ni = 1'b0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_rows[i]) begin
      if (directed_rows[i].op == OP_FREE && !directed_rows[i].typed) begin
        foreach (live_blocks[k]) begin
          if (live_blocks[k] == directed_rows[i].addr) begin
            live_blocks.delete(k);
            break;
          end
        end
      end
      send_request(directed_rows[i].op, directed_rows[i].nbytes, directed_rows[i].addr,
                   directed_rows[i].typed, directed_rows[i].rsp);
    end

    foreach (grow_plan[ph]) begin
      write_grow_min(grow_plan[ph]);
      if (ph == grow_plan.size() - 1) idle_on = 1'b0;
      repeat (PHASE_LEN) random_request();
    end

    // Drain
    req_if.valid <= 1'b0;
    @(posedge clk_i);
    while (expected_rsp.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (error_count == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
